>>> rtl/etsc_pkg.sv
// ----------------------------------------------------------------------------
// etsc_pkg: shared constants for the eye smoothing and crop block
// Register codes, reset values and fixed-point reciprocals used by the
// sequencer and the shared multiplier.
// ----------------------------------------------------------------------------
package etsc_pkg;

  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_COLS = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_ROWS = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_LEFT   = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_TOP    = 4'd3;

  localparam logic [CFG_BITS-1:0] FRAME_COLS_RST = 12'd1920;
  localparam logic [CFG_BITS-1:0] FRAME_ROWS_RST = 12'd1080;

  // eye shift dead zone and span
  localparam int SHIFT_LOW  = 30;
  localparam int SHIFT_HIGH = 300;
  localparam int T_BITS     = 9;

  // w = floor(t * 65536 / 900) = (t * W_RECIP) >> W_SHIFT, exact for t <= 300
  localparam int W_BITS  = 15;
  localparam int W_MAX   = 21845;
  localparam int W_RECIP = 9544372;
  localparam int W_SHIFT = 17;

  localparam int BLEND_SHIFT = 16;
  localparam int BLEND_ROUND = 32768;

  // floor(d * 38 / 10) and floor(d * 53 / 10) via ceil(2^26 / 10)
  localparam int CW_RECIP     = 255013706;
  localparam int CH_RECIP     = 355677011;
  localparam int DIV10_SHIFT  = 26;

  // floor(h * 11 / 26) via 11 * ceil(2^21 / 26)
  localparam int CY_RECIP = 887260;
  localparam int CY_SHIFT = 21;

  // signed width of the a side of the multiplier (constants and the blend weight)
  localparam int MUL_A_BITS = 30;

endpackage

>>> rtl/eye_track_smooth_crop_top.sv
// ----------------------------------------------------------------------------
// eye_track_smooth_crop_top: per-frame eye smoothing and crop window
// Blends the detected eye centres into stored positions, tracks the smile
// intensity and emits a crop rectangle clamped to the frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one detection word per video frame (valid/ready)
//   out_*  one result word per input word (valid/ready)
//   cfg_*  register writes, always ready; write only while the block is idle
// Sequence: a word with a face runs every step; a word without a face
//   goes straight to the crop steps. The block accepts one word at a time
//   (in_ready only while idle). The sequencer steps the four shift
//   terms through the subtractor, then the weight, four blends and
//   three crop products through one multiplier.
// Output: the result sits in an output register; the next word is accepted
//   while it waits. If the receiver stalls, the sequencer holds its last
//   step until the register frees up, so nothing is dropped.
// Reset: stored eyes and intensity clear to zero, frame size to 1920x1080,
//   region offsets to zero, no result pending.
// ----------------------------------------------------------------------------
module eye_track_smooth_crop_top #(
  parameter int COORD_BITS = 12,
  parameter int SCORE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [etsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [etsc_pkg::CFG_BITS-1:0]       cfg_data,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_face_found,
  input  logic [COORD_BITS-1:0]               in_face_x,
  input  logic [COORD_BITS-1:0]               in_face_y,
  input  logic [COORD_BITS-1:0]               in_left_eye_x,
  input  logic [COORD_BITS-1:0]               in_left_eye_y,
  input  logic [COORD_BITS-1:0]               in_right_eye_x,
  input  logic [COORD_BITS-1:0]               in_right_eye_y,
  input  logic [SCORE_BITS-1:0]               in_smile_score,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [etsc_pkg::CFG_BITS-1:0]       out_crop_x,
  output logic [etsc_pkg::CFG_BITS-1:0]       out_crop_y,
  output logic [etsc_pkg::CFG_BITS-1:0]       out_crop_width,
  output logic [etsc_pkg::CFG_BITS-1:0]       out_crop_height,
  output logic [SCORE_BITS-1:0]               out_smooth_intensity,
  output logic [COORD_BITS-1:0]               out_left_x,
  output logic [COORD_BITS-1:0]               out_left_y,
  output logic [COORD_BITS-1:0]               out_right_x,
  output logic [COORD_BITS-1:0]               out_right_y
);

  localparam int CB  = etsc_pkg::CFG_BITS;
  localparam int AW  = ((COORD_BITS > CB) ? COORD_BITS : CB) + 2;
  localparam int DW  = AW + 1;
  localparam int SW  = AW + 2;
  localparam int MA  = etsc_pkg::MUL_A_BITS;
  localparam int MB  = DW;
  localparam int PW  = MA + MB;
  localparam int QW  = PW - etsc_pkg::DIV10_SHIFT;
  localparam int PLW = AW + 1;
  localparam int TW  = etsc_pkg::T_BITS;
  localparam int WB  = etsc_pkg::W_BITS;

  localparam logic signed [PW-1:0]  ROUND_S   = PW'(etsc_pkg::BLEND_ROUND);
  localparam logic signed [PW-1:0]  CMAX_S    = PW'((1 << COORD_BITS) - 1);
  localparam logic signed [PLW-1:0] ONE_S     = PLW'(1);
  localparam logic [SW-1:0]         T_LO      = SW'(etsc_pkg::SHIFT_LOW);
  localparam logic [SW-1:0]         T_HI      =
    SW'(etsc_pkg::SHIFT_LOW + etsc_pkg::SHIFT_HIGH);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_WGT_MUL, S_WGT_GET, S_BL_MUL, S_BL_UPD,
    S_CW_MUL, S_CH_MUL, S_CH_GET, S_CY_MUL, S_FINISH
  } state_t;

  state_t                  state_r;
  logic [1:0]              idx_r;
  logic [CB-1:0]           cols_r, rows_r, roi_x_r, roi_y_r;
  logic [AW-1:0]           cur_r [4];
  logic [COORD_BITS-1:0]   prev_r [4];
  logic [SCORE_BITS-1:0]   int_r;
  logic [SW-1:0]           acc_r;
  logic [WB-1:0]           w_r;
  logic [CB-1:0]           width_r, height_r;
  logic                    out_valid_r;
  logic [CB-1:0]           crop_x_r, crop_y_r, crop_w_r, crop_h_r;
  logic [SCORE_BITS-1:0]   inten_r;
  logic [COORD_BITS-1:0]   eye_r [4];

  logic                    in_acc;
  logic                    out_free;
  logic signed [DW-1:0]    diff;
  logic [SW-1:0]           absd;
  logic [TW-1:0]           t_val;
  logic signed [MA-1:0]    mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    adj, blend_v;
  logic [COORD_BITS-1:0]   blend_sat;
  logic signed [COORD_BITS:0] d_s, dpos;
  logic [CB-1:0]           wlim, hlim;
  logic [QW-1:0]           q_div;
  logic [CB-1:0]           width_nxt, height_nxt;
  logic [COORD_BITS-1:0]   cx, cy;
  logic [COORD_BITS:0]     sum_x, sum_y;
  logic [CB-1:0]           hy;
  logic signed [PLW-1:0]   sx, sy;
  logic [CB-1:0]           crop_x_nxt, crop_y_nxt;

  // place a span of the given size near start inside [0, extent)
  function automatic logic [CB-1:0] place(input logic signed [PLW-1:0] start,
                                          input logic [CB-1:0] size,
                                          input logic [CB-1:0] extent);
    logic signed [PLW-1:0] s, sz, ex;
    s  = start;
    sz = $signed({{(PLW-CB){1'b0}}, size});
    ex = $signed({{(PLW-CB){1'b0}}, extent});
    if (s < 0) s = '0;
    if (s + sz >= ex) s = ex - sz - ONE_S;
    if (s < 0) s = '0;
    return s[CB-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  etsc_mul #(
    .A_BITS (MA),
    .B_BITS (MB)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  always_comb begin
    diff = $signed({1'b0, cur_r[idx_r]})
         - $signed({{(DW-COORD_BITS){1'b0}}, prev_r[idx_r]});
    absd = diff[DW-1] ? SW'(-diff) : SW'(diff);

    // dead zone of SHIFT_LOW, then saturate at SHIFT_HIGH
    if (acc_r <= T_LO) t_val = '0;
    else if (acc_r >= T_HI) t_val = TW'(etsc_pkg::SHIFT_HIGH);
    else t_val = TW'(acc_r - T_LO);

    adj     = (prod_r + ROUND_S) >>> etsc_pkg::BLEND_SHIFT;
    blend_v = adj + $signed({{(PW-COORD_BITS){1'b0}}, prev_r[idx_r]});
    if (blend_v < 0) blend_sat = '0;
    else if (blend_v > CMAX_S) blend_sat = '1;
    else blend_sat = blend_v[COORD_BITS-1:0];

    d_s  = $signed({1'b0, prev_r[2]}) - $signed({1'b0, prev_r[0]});
    dpos = (d_s > 0) ? d_s : '0;

    wlim  = (cols_r == '0) ? '0 : cols_r - CB'(1);
    hlim  = (rows_r == '0) ? '0 : rows_r - CB'(1);
    q_div = prod_r[PW-1:etsc_pkg::DIV10_SHIFT];
    width_nxt  = (q_div > QW'(wlim)) ? wlim : q_div[CB-1:0];
    height_nxt = (q_div > QW'(hlim)) ? hlim : q_div[CB-1:0];

    sum_x = {1'b0, prev_r[0]} + {1'b0, prev_r[2]};
    sum_y = {1'b0, prev_r[1]} + {1'b0, prev_r[3]};
    cx    = sum_x[COORD_BITS:1];
    cy    = sum_y[COORD_BITS:1];
    hy    = prod_r[etsc_pkg::CY_SHIFT +: CB];
    sx    = $signed({{(PLW-COORD_BITS){1'b0}}, cx})
          - $signed({{(PLW-CB+1){1'b0}}, width_r[CB-1:1]});
    sy    = $signed({{(PLW-COORD_BITS){1'b0}}, cy})
          - $signed({{(PLW-CB){1'b0}}, hy});
    crop_x_nxt = place(sx, width_r, cols_r);
    crop_y_nxt = place(sy, height_r, rows_r);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r) inside
      S_WGT_MUL: begin
        mul_a = MA'(etsc_pkg::W_RECIP);
        mul_b = $signed({{(MB-TW){1'b0}}, t_val});
      end
      S_BL_MUL: begin
        mul_a = $signed({{(MA-WB){1'b0}}, w_r});
        mul_b = diff;
      end
      S_CW_MUL: begin
        mul_a = MA'(etsc_pkg::CW_RECIP);
        mul_b = MB'(dpos);
      end
      S_CH_MUL: begin
        mul_a = MA'(etsc_pkg::CH_RECIP);
        mul_b = MB'(dpos);
      end
      // keep the crop y product on while the final step waits
      S_CY_MUL, S_FINISH: begin
        mul_a = MA'(etsc_pkg::CY_RECIP);
        mul_b = $signed({{(MB-CB){1'b0}}, height_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cols_r      <= etsc_pkg::FRAME_COLS_RST;
      rows_r      <= etsc_pkg::FRAME_ROWS_RST;
      roi_x_r     <= '0;
      roi_y_r     <= '0;
      prev_r      <= '{default: '0};
      int_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          etsc_pkg::CFG_FRAME_COLS: cols_r  <= cfg_data;
          etsc_pkg::CFG_FRAME_ROWS: rows_r  <= cfg_data;
          etsc_pkg::CFG_ROI_LEFT:   roi_x_r <= cfg_data;
          etsc_pkg::CFG_ROI_TOP:    roi_y_r <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == S_FINISH && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cur_r[0] <= AW'(roi_x_r) + AW'(in_face_x) + AW'(in_left_eye_x);
            cur_r[1] <= AW'(roi_y_r) + AW'(in_face_y) + AW'(in_left_eye_y);
            cur_r[2] <= AW'(roi_x_r) + AW'(in_face_x) + AW'(in_right_eye_x);
            cur_r[3] <= AW'(roi_y_r) + AW'(in_face_y) + AW'(in_right_eye_y);
            acc_r    <= '0;
            idx_r    <= '0;
            if (in_face_found) begin
              int_r   <= SCORE_BITS'(({1'b0, int_r} + {1'b0, in_smile_score}) >> 1);
              state_r <= S_SUM;
            end else begin
              int_r   <= '0;
              state_r <= S_CW_MUL;
            end
          end
        end
        S_SUM: begin
          acc_r <= acc_r + absd;
          idx_r <= idx_r + 2'd1;
          if (idx_r == 2'd3) state_r <= S_WGT_MUL;
        end
        S_WGT_MUL: state_r <= S_WGT_GET;
        S_WGT_GET: begin
          w_r     <= prod_r[etsc_pkg::W_SHIFT +: WB];
          state_r <= S_BL_MUL;
        end
        S_BL_MUL: state_r <= S_BL_UPD;
        S_BL_UPD: begin
          prev_r[idx_r] <= blend_sat;
          idx_r         <= idx_r + 2'd1;
          state_r       <= (idx_r == 2'd3) ? S_CW_MUL : S_BL_MUL;
        end
        S_CW_MUL: state_r <= S_CH_MUL;
        S_CH_MUL: begin
          width_r <= width_nxt;
          state_r <= S_CH_GET;
        end
        S_CH_GET: begin
          height_r <= height_nxt;
          state_r  <= S_CY_MUL;
        end
        S_CY_MUL: state_r <= S_FINISH;
        S_FINISH: begin
          // hold here until the output register frees up
          if (out_free) begin
            crop_x_r    <= crop_x_nxt;
            crop_y_r    <= crop_y_nxt;
            crop_w_r    <= width_r;
            crop_h_r    <= height_r;
            inten_r     <= int_r;
            eye_r       <= prev_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_crop_x           = crop_x_r;
  assign out_crop_y           = crop_y_r;
  assign out_crop_width       = crop_w_r;
  assign out_crop_height      = crop_h_r;
  assign out_smooth_intensity = inten_r;
  assign out_left_x           = eye_r[0];
  assign out_left_y           = eye_r[1];
  assign out_right_x          = eye_r[2];
  assign out_right_y          = eye_r[3];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block took a word without leaving idle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result word loaded outside the final step");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && out_valid_r && !out_ready |=> state_r == S_FINISH)
    else $error("sequencer left final step while output was stalled");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BL_MUL |-> w_r <= WB'(etsc_pkg::W_MAX))
    else $error("blend weight above one third");

endmodule

>>> rtl/etsc_mul.sv
// ----------------------------------------------------------------------------
// etsc_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module etsc_mul #(
  parameter int A_BITS = 30,
  parameter int B_BITS = 15
) (
  input  logic                             clk,
  input  logic signed [A_BITS-1:0]         a,
  input  logic signed [B_BITS-1:0]         b,
  output logic signed [A_BITS+B_BITS-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
  end

endmodule
